/* sv/chc_pkg.sv */
// Shared types, command codes and the arctangent table for the compass heading calibrator.
`timescale 1ns / 1ps
`default_nettype none

package chc_pkg;

   localparam int          PROD_W      = 34;
   localparam logic [15:0] QUIET_RESET = 16'd5000;

   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_SAMPLE = 2'd1;
   localparam logic [1:0] CMD_START  = 2'd2;
   localparam logic [1:0] CMD_REZERO = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_LAUNCH,
      ST_ANGLE,
      ST_WRAP,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_ITER,
      CS_ROUND
   } cordic_state_type;

   typedef struct packed {
      logic              done;
      logic signed [8:0] angle;
   } cordic_res_type;

   // atan(2^-i) in degrees, scaled by 2^24
   function automatic logic [29:0] atan_tab(input logic [4:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'd754974720;
         5'd1:  v = 30'd445687602;
         5'd2:  v = 30'd235489088;
         5'd3:  v = 30'd119537938;
         5'd4:  v = 30'd60000934;
         5'd5:  v = 30'd30029717;
         5'd6:  v = 30'd15018523;
         5'd7:  v = 30'd7509720;
         5'd8:  v = 30'd3754917;
         5'd9:  v = 30'd1877466;
         5'd10: v = 30'd938734;
         5'd11: v = 30'd469367;
         5'd12: v = 30'd234684;
         5'd13: v = 30'd117342;
         5'd14: v = 30'd58671;
         5'd15: v = 30'd29335;
         5'd16: v = 30'd14668;
         5'd17: v = 30'd7334;
         5'd18: v = 30'd3667;
         5'd19: v = 30'd1833;
         5'd20: v = 30'd917;
         5'd21: v = 30'd458;
         5'd22: v = 30'd229;
         5'd23: v = 30'd115;
         5'd24: v = 30'd57;
         5'd25: v = 30'd29;
         5'd26: v = 30'd14;
         5'd27: v = 30'd7;
         5'd28: v = 30'd4;
         5'd29: v = 30'd2;
         5'd30: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

   // (a+b)/2 truncated toward zero
   function automatic logic signed [15:0] half_sum(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
      logic signed [16:0] s;
      s = {a[15], a} + {b[15], b};
      s = s + {16'd0, s[16]};
      return s[16:1];
   endfunction

   // a-b, a zero span reads as one
   function automatic logic [16:0] span_of(input logic signed [15:0] a,
                                          input logic signed [15:0] b);
      logic [16:0] d;
      d = {a[15], a} - {b[15], b};
      return (d == 17'd0) ? 17'd1 : d;
   endfunction

endpackage

`default_nettype wire

/* sv/chc_req_if.sv */
// Request channel interface: command and magnetometer sample.
`timescale 1ns / 1ps
`default_nettype none

interface chc_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic signed [15:0] sample_x;
   logic signed [15:0] sample_y;
   logic signed [15:0] sample_z;
   logic               data_ready;
   logic               overflow;

   modport source (output valid, cmd, sample_x, sample_y, sample_z, data_ready, overflow,
                   input ready);
   modport sink   (input valid, cmd, sample_x, sample_y, sample_z, data_ready, overflow,
                   output ready);
endinterface

`default_nettype wire

/* sv/chc_rsp_if.sv */
// Response channel interface: heading and status flags.
`timescale 1ns / 1ps
`default_nettype none

interface chc_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] heading_deg;
   logic       new_heading;
   logic       calibrating;
   logic       cal_finished;
   logic       rezero_ok;

   modport source (output valid, heading_deg, new_heading, calibrating, cal_finished,
                   rezero_ok, input ready);
   modport sink   (input valid, heading_deg, new_heading, calibrating, cal_finished,
                   rezero_ok, output ready);
endinterface

`default_nettype wire

/* sv/compass_heading_calibrator.sv */
// Top level: magnetometer hard-iron calibration and compass heading sequencer.
//
// One item is taken at a time. A tick, a start, a sample during calibration, an
// invalid sample or an invalid re-zero goes from decode to the done state and the
// output register, and the input is ready again in the cycle its result appears. A
// valid heading or re-zero sample scales the centred x and y by the opposite spans
// on one shared 17x18 multiplier, x then y, then runs up to CORDIC_STEPS
// micro-rotations on the iterative vectoring unit; an exact axis skips them. A
// heading then has the re-zero angle subtracted and 360 added while it is negative;
// a re-zero stores its angle, made non-negative, instead. The result sits in an
// output register, and the next item is taken while it waits to be collected; a
// second result waits in the sequencer until the first has gone.
`timescale 1ns / 1ps
`default_nettype none

module compass_heading_calibrator
   import chc_pkg::*;
#(
   parameter int CORDIC_STEPS    = 20,
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   chc_req_if.sink          req_ch,
   chc_rsp_if.source        rsp_ch
);

   state_type                state_ff, state_in;
   logic [15:0]              quiet_ticks_ff, quiet_ticks_in;
   logic [1:0]               cmd_ff, cmd_in;
   logic signed [15:0]       samp_ff [3];
   logic signed [15:0]       samp_in [3];
   logic                     valid_ff, valid_in;
   logic signed [15:0]       min_ff [3];
   logic signed [15:0]       min_in [3];
   logic signed [15:0]       max_ff [3];
   logic signed [15:0]       max_in [3];
   logic signed [15:0]       offset_x_ff, offset_x_in, offset_y_ff, offset_y_in;
   logic [16:0]              span_x_ff, span_x_in, span_y_ff, span_y_in;
   logic [15:0]              quiet_count_ff, quiet_count_in, count_inc;
   logic                     cal_active_ff, cal_active_in;
   logic [8:0]               rezero_ff, rezero_in;
   logic [8:0]               last_heading_ff, last_heading_in;
   logic signed [PROD_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [10:0]       h_ff, h_in;
   logic                     fresh_ff, fresh_in, finished_ff, finished_in;
   logic                     rz_ok_ff, rz_ok_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [8:0]               rsp_heading_ff, rsp_heading_in;
   logic                     rsp_fresh_ff, rsp_fresh_in, rsp_cal_ff, rsp_cal_in;
   logic                     rsp_fin_ff, rsp_fin_in, rsp_rz_ff, rsp_rz_in;

   logic                     mul_sel;
   logic signed [16:0]       mul_a;
   logic signed [17:0]       mul_b;
   logic signed [34:0]       product;
   logic                     cordic_start;
   cordic_res_type           cordic_res;
   logic                     changed;

   chc_cordic #(
      .CORDIC_STEPS    (CORDIC_STEPS),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .x_in  (cx_ff),
      .y_in  (cy_ff),
      .res   (cordic_res)
   );

   // shared multiplier: centred sample times the opposite axis span
   assign mul_a   = mul_sel ? ({samp_ff[1][15], samp_ff[1]} - {offset_y_ff[15], offset_y_ff})
                            : ({samp_ff[0][15], samp_ff[0]} - {offset_x_ff[15], offset_x_ff});
   assign mul_b   = $signed({1'b0, (mul_sel ? span_x_ff : span_y_ff)});
   assign product = mul_a * mul_b;

   assign count_inc = (quiet_count_ff != 16'hFFFF) ? quiet_count_ff + 16'd1 : quiet_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         quiet_ticks_ff  <= QUIET_RESET;
         min_ff          <= '{default: '0};
         max_ff          <= '{default: '0};
         offset_x_ff     <= '0;
         offset_y_ff     <= '0;
         span_x_ff       <= 17'd1;
         span_y_ff       <= 17'd1;
         quiet_count_ff  <= '0;
         cal_active_ff   <= 1'b0;
         rezero_ff       <= '0;
         last_heading_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         quiet_ticks_ff  <= quiet_ticks_in;
         min_ff          <= min_in;
         max_ff          <= max_in;
         offset_x_ff     <= offset_x_in;
         offset_y_ff     <= offset_y_in;
         span_x_ff       <= span_x_in;
         span_y_ff       <= span_y_in;
         quiet_count_ff  <= quiet_count_in;
         cal_active_ff   <= cal_active_in;
         rezero_ff       <= rezero_in;
         last_heading_ff <= last_heading_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      samp_ff        <= samp_in;
      valid_ff       <= valid_in;
      cx_ff          <= cx_in;
      cy_ff          <= cy_in;
      h_ff           <= h_in;
      fresh_ff       <= fresh_in;
      finished_ff    <= finished_in;
      rz_ok_ff       <= rz_ok_in;
      rsp_heading_ff <= rsp_heading_in;
      rsp_fresh_ff   <= rsp_fresh_in;
      rsp_cal_ff     <= rsp_cal_in;
      rsp_fin_ff     <= rsp_fin_in;
      rsp_rz_ff      <= rsp_rz_in;
   end

   always_comb begin
      state_in        = state_ff;
      quiet_ticks_in  = csr_wr_en ? csr_wr_data : quiet_ticks_ff;
      cmd_in          = cmd_ff;
      samp_in         = samp_ff;
      valid_in        = valid_ff;
      min_in          = min_ff;
      max_in          = max_ff;
      offset_x_in     = offset_x_ff;
      offset_y_in     = offset_y_ff;
      span_x_in       = span_x_ff;
      span_y_in       = span_y_ff;
      quiet_count_in  = quiet_count_ff;
      cal_active_in   = cal_active_ff;
      rezero_in       = rezero_ff;
      last_heading_in = last_heading_ff;
      cx_in           = cx_ff;
      cy_in           = cy_ff;
      h_in            = h_ff;
      fresh_in        = fresh_ff;
      finished_in     = finished_ff;
      rz_ok_in        = rz_ok_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ch.ready;
      rsp_heading_in  = rsp_heading_ff;
      rsp_fresh_in    = rsp_fresh_ff;
      rsp_cal_in      = rsp_cal_ff;
      rsp_fin_in      = rsp_fin_ff;
      rsp_rz_in       = rsp_rz_ff;
      mul_sel         = 1'b0;
      cordic_start    = 1'b0;
      changed         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               cmd_in      = req_ch.cmd;
               samp_in[0]  = req_ch.sample_x;
               samp_in[1]  = req_ch.sample_y;
               samp_in[2]  = req_ch.sample_z;
               valid_in    = req_ch.data_ready & ~req_ch.overflow;
               fresh_in    = 1'b0;
               finished_in = 1'b0;
               rz_ok_in    = 1'b0;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_DONE;
            case (cmd_ff)
               CMD_TICK: begin
                  if (cal_active_ff) begin
                     quiet_count_in = count_inc;
                     if (count_inc >= quiet_ticks_ff) begin
                        offset_x_in   = half_sum(max_ff[0], min_ff[0]);
                        offset_y_in   = half_sum(max_ff[1], min_ff[1]);
                        span_x_in     = span_of(max_ff[0], min_ff[0]);
                        span_y_in     = span_of(max_ff[1], min_ff[1]);
                        cal_active_in = 1'b0;
                        finished_in   = 1'b1;
                     end
                  end
               end
               CMD_START: begin
                  min_in         = samp_ff;
                  max_in         = samp_ff;
                  quiet_count_in = '0;
                  cal_active_in  = 1'b1;
               end
               CMD_SAMPLE: begin
                  if (valid_ff && cal_active_ff) begin
                     for (int k = 0; k < 3; k++) begin
                        if (samp_ff[k] > max_ff[k]) begin
                           max_in[k] = samp_ff[k];
                           changed   = 1'b1;
                        end
                        if (samp_ff[k] < min_ff[k]) begin
                           min_in[k] = samp_ff[k];
                           changed   = 1'b1;
                        end
                     end
                     if (changed) begin
                        quiet_count_in = '0;
                     end
                  end else if (valid_ff) begin
                     state_in = ST_MUL_X;
                  end
               end
               default: begin
                  if (valid_ff) begin
                     state_in = ST_MUL_X;
                  end else begin
                     rezero_in = '0;
                  end
               end
            endcase
         end
         ST_MUL_X: begin
            cx_in    = product[PROD_W-1:0];
            state_in = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            mul_sel  = 1'b1;
            cy_in    = product[PROD_W-1:0];
            state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            cordic_start = 1'b1;
            state_in     = ST_ANGLE;
         end
         ST_ANGLE: begin
            if (cordic_res.done) begin
               if (cmd_ff == CMD_REZERO) begin
                  rezero_in = cordic_res.angle[8]
                            ? 9'({cordic_res.angle[8], cordic_res.angle} + 10'd360)
                            : cordic_res.angle[8:0];
                  rz_ok_in  = 1'b1;
                  state_in  = ST_DONE;
               end else begin
                  h_in     = {{2{cordic_res.angle[8]}}, cordic_res.angle} - {2'b00, rezero_ff};
                  state_in = ST_WRAP;
               end
            end
         end
         ST_WRAP: begin
            if (h_ff[10]) begin
               h_in = h_ff + 11'sd360;
            end else begin
               last_heading_in = h_ff[8:0];
               fresh_in        = 1'b1;
               state_in        = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_heading_in = last_heading_ff;
               rsp_fresh_in   = fresh_ff;
               rsp_cal_in     = cal_active_ff;
               rsp_fin_in     = finished_ff;
               rsp_rz_in      = rz_ok_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.heading_deg  = rsp_heading_ff;
   assign rsp_ch.new_heading  = rsp_fresh_ff;
   assign rsp_ch.calibrating  = rsp_cal_ff;
   assign rsp_ch.cal_finished = rsp_fin_ff;
   assign rsp_ch.rezero_ok    = rsp_rz_ff;

endmodule

`default_nettype wire

/* sv/chc_cordic.sv */
// Iterative vectoring CORDIC: atan2 in whole degrees, one micro-rotation per cycle.
`timescale 1ns / 1ps
`default_nettype none

module chc_cordic
   import chc_pkg::*;
#(
   parameter int CORDIC_STEPS    = 20,
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [PROD_W-1:0] x_in,
   input  wire logic signed [PROD_W-1:0] y_in,
   output      cordic_res_type           res
);

   localparam int STEPS     = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
   localparam int CNT_W     = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int XY_W      = PROD_W + 2;
   localparam int Z_W       = ANGLE_FRAC_BITS + 10;
   localparam int TAB_SHIFT = 24 - ANGLE_FRAC_BITS;
   localparam logic signed [Z_W-1:0] Z_90 = Z_W'(90) << ANGLE_FRAC_BITS;

   cordic_state_type        cst_ff, cst_in;
   logic signed [XY_W-1:0]  x_ff, x_in_r, y_ff, y_in_r;
   logic signed [Z_W-1:0]   z_ff, z_in;
   logic [CNT_W-1:0]        i_ff, i_in;
   logic                    done_ff, done_in;
   logic signed [8:0]       angle_ff, angle_in;

   logic signed [XY_W-1:0]  dx, dy, xs, ys;
   logic signed [Z_W-1:0]   step_angle, z_mag;
   logic [9:0]              deg;

   always_ff @(posedge clock) begin
      if (reset) begin
         cst_ff  <= CS_IDLE;
         done_ff <= 1'b0;
      end else begin
         cst_ff  <= cst_in;
         done_ff <= done_in;
      end
      x_ff     <= x_in_r;
      y_ff     <= y_in_r;
      z_ff     <= z_in;
      i_ff     <= i_in;
      angle_ff <= angle_in;
   end

   always_comb begin
      cst_in     = cst_ff;
      x_in_r     = x_ff;
      y_in_r     = y_ff;
      z_in       = z_ff;
      i_in       = i_ff;
      done_in    = 1'b0;
      angle_in   = angle_ff;
      xs         = XY_W'(x_in);
      ys         = XY_W'(y_in);
      dx         = y_ff >>> i_ff;
      dy         = x_ff >>> i_ff;
      step_angle = Z_W'(atan_tab(5'(i_ff)) >> TAB_SHIFT);
      z_mag      = z_ff[Z_W-1] ? -z_ff : z_ff;
      deg        = z_mag[Z_W-1:ANGLE_FRAC_BITS];
      case (cst_ff)
         CS_IDLE: begin
            if (start) begin
               i_in = '0;
               if (y_in == '0) begin
                  angle_in = x_in[PROD_W-1] ? 9'sd180 : 9'sd0;
                  done_in  = 1'b1;
               end else if (x_in == '0) begin
                  angle_in = y_in[PROD_W-1] ? -9'sd90 : 9'sd90;
                  done_in  = 1'b1;
               end else begin
                  cst_in = CS_ITER;
                  if (!x_in[PROD_W-1]) begin
                     x_in_r = xs;
                     y_in_r = ys;
                     z_in   = '0;
                  end else if (!y_in[PROD_W-1]) begin
                     x_in_r = ys;
                     y_in_r = -xs;
                     z_in   = Z_90;
                  end else begin
                     x_in_r = -ys;
                     y_in_r = xs;
                     z_in   = -Z_90;
                  end
               end
            end
         end
         CS_ITER: begin
            if (!y_ff[XY_W-1]) begin
               x_in_r = x_ff + dx;
               y_in_r = y_ff - dy;
               z_in   = z_ff + step_angle;
            end else begin
               x_in_r = x_ff - dx;
               y_in_r = y_ff + dy;
               z_in   = z_ff - step_angle;
            end
            if (i_ff == CNT_W'(STEPS - 1)) begin
               cst_in = CS_ROUND;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         CS_ROUND: begin
            angle_in = z_ff[Z_W-1] ? 9'(10'd0 - deg) : deg[8:0];
            done_in  = 1'b1;
            cst_in   = CS_IDLE;
         end
         default: cst_in = CS_IDLE;
      endcase
   end

   assign res.done  = done_ff;
   assign res.angle = angle_ff;

endmodule

`default_nettype wire

/* sv/chc_checker.sv */
// Port-level assertions for the compass heading calibrator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module chc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [8:0] heading_deg,
   input wire logic       new_heading,
   input wire logic       calibrating,
   input wire logic       cal_finished,
   input wire logic       rezero_ok
);

   // a stalled item holds its heading and new-heading flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(heading_deg) && $stable(new_heading))
      else $error("stalled item changed");

   // one item in flight: no acceptance on the cycle after one
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> heading_deg <= 9'd359)
      else $error("heading out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && cal_finished |-> !calibrating && !new_heading && !rezero_ok)
      else $error("finish flag with other status");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && new_heading |-> !calibrating && !rezero_ok)
      else $error("heading made during calibration");

endmodule

bind compass_heading_calibrator chc_checker u_chc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .heading_deg  (rsp_ch.heading_deg),
   .new_heading  (rsp_ch.new_heading),
   .calibrating  (rsp_ch.calibrating),
   .cal_finished (rsp_ch.cal_finished),
   .rezero_ok    (rsp_ch.rezero_ok)
);

`default_nettype wire
